[design/abp_pkg.sv]
// ----------------------------------------------------------------------------
// abp_pkg - shared constants and helpers for the ARX-box branch permutation
// Round constants, ARX-box rotation amounts, register indexes, rotate and
// linear-layer mixing functions.
// ----------------------------------------------------------------------------
package abp_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes
  localparam logic [1:0] REG_BRANCH_COUNT = 2'd0;
  localparam logic [1:0] REG_STEP_COUNT   = 2'd1;
  localparam logic [1:0] REG_DIRECTION    = 2'd2;

  // Round constants, one per branch and one per step (mod 8)
  localparam word_t RC [8] = '{
    32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
    32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
  };

  // Forward round rotations: A on y before the add, B on x into y
  localparam int ROT_A [4] = '{31, 17, 0, 24};
  localparam int ROT_B [4] = '{24, 17, 31, 16};

  function automatic word_t rotr(input word_t v, input int unsigned n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> n;
    return d[WORD_W-1:0];
  endfunction

  function automatic word_t ell(input word_t v);
    word_t t;
    t = v ^ (v << 16);
    return rotr(t, 16);
  endfunction

endpackage

[design/abp_round.sv]
// ----------------------------------------------------------------------------
// abp_round - one ARX-box round on a single branch
// Shared add/subtract unit; forward does add-rotate-xor, inverse undoes the
// round whose rotations mirror the given round index.
// ----------------------------------------------------------------------------
module abp_round import abp_pkg::*; (
  input  logic       inverse,
  input  logic [1:0] rnd,
  input  word_t      key,
  input  word_t      x_in,
  input  word_t      y_in,
  output word_t      x_out,
  output word_t      y_out
);

  logic [1:0] idx;
  word_t      x_key;
  word_t      y_inv;
  word_t      y_fwd;
  word_t      add_a;
  word_t      add_b;
  word_t      sum;

  function automatic word_t rot_a(input word_t v, input logic [1:0] i);
    word_t r;
    unique case (i)
      2'd0: r = rotr(v, ROT_A[0]);
      2'd1: r = rotr(v, ROT_A[1]);
      2'd2: r = rotr(v, ROT_A[2]);
      2'd3: r = rotr(v, ROT_A[3]);
    endcase
    return r;
  endfunction

  function automatic word_t rot_b(input word_t v, input logic [1:0] i);
    word_t r;
    unique case (i)
      2'd0: r = rotr(v, ROT_B[0]);
      2'd1: r = rotr(v, ROT_B[1]);
      2'd2: r = rotr(v, ROT_B[2]);
      2'd3: r = rotr(v, ROT_B[3]);
    endcase
    return r;
  endfunction

  // inverse walks the rounds backwards
  assign idx   = inverse ? ~rnd : rnd;
  assign x_key = x_in ^ key;
  assign y_inv = y_in ^ rot_b(x_key, idx);

  assign add_a = inverse ? x_key : x_in;
  assign add_b = rot_a(inverse ? y_inv : y_in, idx) ^ {WORD_W{inverse}};
  assign sum   = add_a + add_b + {{(WORD_W-1){1'b0}}, inverse};

  assign y_fwd = y_in ^ rot_b(sum, idx);

  assign x_out = inverse ? sum : (sum ^ key);
  assign y_out = inverse ? y_inv : y_fwd;

endmodule

[design/abp_linear.sv]
// ----------------------------------------------------------------------------
// abp_linear - Feistel-like linear layer over the whole state
// Forward mixes the left half into the right and swaps; inverse undoes it.
// One candidate wiring per supported half-width, picked by the live count.
// ----------------------------------------------------------------------------
module abp_linear import abp_pkg::*; #(
  parameter int N      = 8,
  parameter int HALF_W = $clog2(N/2 + 1)
) (
  input  logic                  inverse,
  input  logic [HALF_W-1:0]     half,
  input  logic [N-1:0][WORD_W-1:0] x_in,
  input  logic [N-1:0][WORD_W-1:0] y_in,
  output logic [N-1:0][WORD_W-1:0] x_out,
  output logic [N-1:0][WORD_W-1:0] y_out
);

  always_comb begin
    word_t ax;
    word_t ay;
    word_t tx;
    word_t ty;
    int    nx;
    int    pv;
    x_out = x_in;
    y_out = y_in;
    ax    = '0;
    ay    = '0;
    tx    = '0;
    ty    = '0;
    nx    = 0;
    pv    = 0;
    for (int hv = 2; hv <= N/2; hv++) begin
      if (half == HALF_W'(hv)) begin
        ax = '0;
        ay = '0;
        for (int i = 0; i < hv; i++) begin
          if (inverse) begin
            ax = ax ^ x_in[hv+i];
            ay = ay ^ y_in[hv+i];
          end else begin
            ax = ax ^ x_in[i];
            ay = ay ^ y_in[i];
          end
        end
        tx = ell(ax);
        ty = ell(ay);
        for (int i = 0; i < hv; i++) begin
          nx = (i + 1 == hv) ? 0 : i + 1;
          pv = (i == 0) ? hv - 1 : i - 1;
          // note the cross-over: x words take ty, y words take tx
          if (inverse) begin
            x_out[i]    = x_in[hv+i];
            y_out[i]    = y_in[hv+i];
            x_out[hv+i] = x_in[pv] ^ x_in[hv+i] ^ ty;
            y_out[hv+i] = y_in[pv] ^ y_in[hv+i] ^ tx;
          end else begin
            x_out[i]    = x_in[hv+nx] ^ x_in[nx] ^ ty;
            y_out[i]    = y_in[hv+nx] ^ y_in[nx] ^ tx;
            x_out[hv+i] = x_in[i];
            y_out[hv+i] = y_in[i];
          end
        end
      end
    end
  end

endmodule

[design/arxbox_branch_permutation_unit.sv]
// Loading: b branches are loaded one per cycle while in_valid is high; the
// permutation then runs S steps, each one ARX layer (one ARX round per cycle on
// the shared round unit), one step-constant state and one linear-layer state.
// Results follow one branch per cycle while out_ready is high.
// A new block is only taken once the last result branch has been emitted.
// Reset: synchronous; back to loading, config to 4 branches, 7 steps, forward.
// ----------------------------------------------------------------------------
// arxbox_branch_permutation_unit - branch-serial ARX-box permutation
// Loads the state branch by branch, runs the forward or inverse permutation
// on a shared round unit under a small sequencer and streams the result out.
// ----------------------------------------------------------------------------
module arxbox_branch_permutation_unit import abp_pkg::*; #(
  parameter int MAX_BRANCH_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] branch_x,
  input  logic [31:0] branch_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_last
);

  localparam int BW     = $clog2(MAX_BRANCH_COUNT);
  localparam int LCW    = $clog2(MAX_BRANCH_COUNT + 1);
  localparam int HALF_W = $clog2(MAX_BRANCH_COUNT/2 + 1);
  localparam logic [3:0] MAX_B = 4'(MAX_BRANCH_COUNT);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CONST = 3'd1;
  localparam logic [2:0] S_ARX   = 3'd2;
  localparam logic [2:0] S_LIN   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]     state;
  logic [3:0]     branch_count;
  logic [4:0]     step_count;
  logic           direction;
  logic [LCW-1:0] load_count;
  logic [LCW-1:0] load_inc;
  logic [4:0]     step_num;
  logic [4:0]     step_inc;
  logic [4:0]     step_const;
  logic [BW-1:0]  br;
  logic [1:0]     rnd;
  logic [BW-1:0]  em;

  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] sx;
  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] sy;
  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] lx;
  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] ly;
  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] rot_x;
  logic [MAX_BRANCH_COUNT-1:0][WORD_W-1:0] rot_y;

  logic [3:0]    b_clamp;
  logic [3:0]    b_eff;
  logic [3:0]    b_last;
  logic [BW-1:0] slot;
  logic          in_fire;
  logic          out_fire;
  logic          load_done;
  logic          step_last;
  logic          arx_last;
  word_t         rx;
  word_t         ry;
  word_t         head_x;
  word_t         head_y;

  // out-of-range counts clamp to 4..MAX_B, and odd counts round down to even
  assign b_clamp = (branch_count < 4'd4) ? 4'd4 :
                   (branch_count > MAX_B) ? MAX_B : branch_count;
  assign b_eff   = {b_clamp[3:1], 1'b0};
  assign b_last  = b_eff - 4'd1;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign slot      = load_count[BW-1:0];
  assign load_inc  = load_count + LCW'(1);
  assign load_done = (4'(load_inc) >= b_eff);
  assign step_inc  = step_num + 5'd1;
  assign step_last = (step_inc == step_count);
  assign arx_last  = (rnd == 2'd3) && (4'(br) == b_last);
  assign step_const = direction ? (step_count - 5'd1 - step_num) : step_num;

  assign out_x    = sx[0];
  assign out_y    = sy[0];
  assign out_last = (4'(em) == b_last);

  abp_round u_round (
    .inverse (direction),
    .rnd     (rnd),
    .key     (RC[3'(br)]),
    .x_in    (sx[0]),
    .y_in    (sy[0]),
    .x_out   (rx),
    .y_out   (ry)
  );

  abp_linear #(
    .N      (MAX_BRANCH_COUNT),
    .HALF_W (HALF_W)
  ) u_linear (
    .inverse (direction),
    .half    (HALF_W'(b_eff >> 1)),
    .x_in    (sx),
    .y_in    (sy),
    .x_out   (lx),
    .y_out   (ly)
  );

  // rotate the live branches down by one; the head re-enters at the top
  assign head_x = (state == S_ARX) ? rx : sx[0];
  assign head_y = (state == S_ARX) ? ry : sy[0];

  always_comb begin
    for (int i = 0; i < MAX_BRANCH_COUNT - 1; i++) begin
      rot_x[i] = sx[i+1];
      rot_y[i] = sy[i+1];
    end
    rot_x[MAX_BRANCH_COUNT-1] = sx[MAX_BRANCH_COUNT-1];
    rot_y[MAX_BRANCH_COUNT-1] = sy[MAX_BRANCH_COUNT-1];
    for (int i = 0; i < MAX_BRANCH_COUNT; i++) begin
      if (4'(i) == b_last) begin
        rot_x[i] = head_x;
        rot_y[i] = head_y;
      end
    end
  end

  // state words
  always_ff @(posedge clk) begin
    priority if (in_fire) begin
      sx[slot] <= branch_x;
      sy[slot] <= branch_y;
    end else if (state == S_CONST) begin
      sy[0] <= sy[0] ^ RC[step_const[2:0]];
      sy[1] <= sy[1] ^ WORD_W'(step_const);
    end else if (state == S_LIN) begin
      sx <= lx;
      sy <= ly;
    end else if (state == S_ARX) begin
      if (rnd == 2'd3) begin
        sx <= rot_x;
        sy <= rot_y;
      end else begin
        sx[0] <= rx;
        sy[0] <= ry;
      end
    end else if (out_fire) begin
      sx <= rot_x;
      sy <= rot_y;
    end
  end

  // sequencer and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      branch_count <= 4'd4;
      step_count   <= 5'd7;
      direction    <= 1'b0;
      load_count   <= '0;
      step_num     <= '0;
      br           <= '0;
      rnd          <= '0;
      em           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BRANCH_COUNT: branch_count <= cfg_data[3:0];
          REG_STEP_COUNT:   step_count   <= cfg_data;
          REG_DIRECTION:    direction    <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (load_done) begin
              load_count <= '0;
              step_num   <= '0;
              br         <= '0;
              rnd        <= '0;
              em         <= '0;
              if (step_count == 5'd0) begin
                state <= S_EMIT;
              end else if (direction) begin
                state <= S_LIN;
              end else begin
                state <= S_CONST;
              end
            end else begin
              load_count <= load_inc;
            end
          end
        end
        S_CONST: begin
          if (!direction) begin
            state <= S_ARX;
          end else begin
            step_num <= step_inc;
            state    <= step_last ? S_EMIT : S_LIN;
          end
        end
        S_ARX: begin
          rnd <= rnd + 2'd1;
          if (rnd == 2'd3) begin
            if (arx_last) begin
              br    <= '0;
              state <= direction ? S_CONST : S_LIN;
            end else begin
              br <= br + BW'(1);
            end
          end
        end
        S_LIN: begin
          if (direction) begin
            state <= S_ARX;
          end else begin
            step_num <= step_inc;
            state    <= step_last ? S_EMIT : S_CONST;
          end
        end
        S_EMIT: begin
          if (out_fire) begin
            if (out_last) begin
              em    <= '0;
              state <= S_LOAD;
            end else begin
              em <= em + BW'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count < LCW'(MAX_BRANCH_COUNT))
    else $error("load count reached the state size");

  a_load_count_clear: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (load_count == '0))
    else $error("load count not cleared while busy");

  a_last_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("no return to loading after last branch");

  a_arx_branch_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ARX) |-> (4'(br) <= b_last))
    else $error("ARX branch index beyond live state");

  a_arx_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ARX && arx_last) |=> (state == S_LIN || state == S_CONST))
    else $error("ARX layer did not hand over");
`endif

endmodule
